/* rtl/wpm_pkg.sv */
// Package: shared types and constants for the weight prune mask updater.
package wpm_pkg;

  localparam logic [1:0] FUNC_STATS  = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_APPLY  = 2'd2;

  localparam logic KIND_STATS  = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] weight_value;
    logic               mask_bit;
    logic               last_item;
  } wpm_in_t;

  typedef struct packed {
    logic               result_kind;
    logic               new_mask;
    logic               mask_changed;
    logic signed [15:0] masked_weight;
    logic [14:0]        mean_out;
    logic [15:0]        stdev_out;
    logic               stats_error;
  } wpm_out_t;

  // controller to datapath
  typedef struct packed {
    logic accum;      // accumulate the held item
    logic weight;     // form the per-weight result
    logic start_fin;  // begin closing the statistics pass
    logic div_step;   // one bit step of the running divide
    logic sub_mul;    // latch m0 and form m0*m0
    logic var_load;   // load variance divide
    logic sqrt_step;  // one step of square root
    logic finish;     // latch statistics result, clear sums
  } wpm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } wpm_sts_t;

endpackage

/* rtl/wpm_ctrl.sv */
// Controller: sequences accumulate, update, apply and the closing divide and square root.
module wpm_ctrl
  import wpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  input  wpm_in_t  in_item_i,
  output logic     in_stall,
  input  logic     out_busy_i,
  output logic     take_o,
  output wpm_cmd_t cmd_o,
  input  wpm_sts_t sts_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVM  = 7'b0000010,
    ST_SUB   = 7'b0000100,
    ST_VLOAD = 7'b0001000,
    ST_DIVV  = 7'b0010000,
    ST_SQRT  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   closes;

  assign closes = (in_item_i.func == FUNC_STATS) && in_item_i.last_item;
  // a closing item waits for a free output; per-weight items also need one
  assign in_stall = (state_q != ST_IDLE) ||
                    (out_busy_i && (in_item_i.func != FUNC_STATS || closes));
  assign take_o = in_valid && !in_stall;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (take_o) begin
          cmd_o.accum  = (in_item_i.func == FUNC_STATS);
          cmd_o.weight = (in_item_i.func == FUNC_UPDATE) || (in_item_i.func == FUNC_APPLY);
          if (closes) begin
            cmd_o.start_fin = 1'b1;
            state_d = ST_DIVM;
          end
        end
      end
      ST_DIVM: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub_mul = 1'b1;
        state_d = ST_VLOAD;
      end
      ST_VLOAD: begin
        cmd_o.var_load = 1'b1;
        state_d = ST_DIVV;
      end
      ST_DIVV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/wpm_datapath.sv */
// Datapath: accumulators, threshold compare, serial divider and square root.
module wpm_datapath
  import wpm_pkg::*;
#(
  parameter int unsigned COUNT_LIMIT = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wpm_in_t     in_item_i,
  input  logic [15:0] crate_i,
  input  wpm_cmd_t    cmd_i,
  output wpm_sts_t    sts_o,
  input  logic        out_take_i,
  output logic        out_valid_o,
  output wpm_out_t    out_item_o
);

  logic [31:0] abs_sum_q;
  logic [47:0] sq_sum_q;
  logic [16:0] cnt_q;
  logic [14:0] mean_q;
  logic [15:0] std_q;

  logic        [15:0] aw;
  logic        [31:0] aw_sq;
  logic signed [15:0] w;
  assign w  = in_item_i.weight_value;
  assign aw = w[15] ? 16'(-w) : 16'(w);
  assign aw_sq = aw * aw;

  // threshold: T = mean*4096 + crate*std, Q21.12
  logic signed [32:0] prod;
  logic signed [33:0] t_raw;
  logic        [32:0] t_pos;
  logic        [36:0] t9, t11;
  logic        [35:0] a10;
  logic               nm;
  assign prod  = $signed(crate_i) * $signed({1'b0, std_q});
  assign t_raw = $signed({7'd0, mean_q, 12'd0}) + 34'(prod);
  assign t_pos = t_raw[33] ? '0 : t_raw[32:0];
  assign t9    = 37'(t_pos) * 37'd9;
  assign t11   = 37'(t_pos) * 37'd11;
  assign a10   = {20'd0, aw} * 36'd40960;

  always_comb begin
    nm = in_item_i.mask_bit;
    if (in_item_i.func == FUNC_UPDATE) begin
      if (in_item_i.mask_bit && (37'(a10) <= t9)) nm = 1'b0;
      else if (!in_item_i.mask_bit && (37'(a10) > t11)) nm = 1'b1;
    end
  end

  // serial restoring divider, 48-bit dividend by 17-bit divisor
  logic [47:0] quo_q;
  logic [17:0] rem_q;
  logic [5:0]  dcnt_q;
  logic [17:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_q[16:0], quo_q[47]};
  assign ge     = rem_sh >= {1'b0, cnt_q};
  assign sts_o.div_done = (dcnt_q == 6'd47);

  // m0*m0 is formed first, count*(m0*m0) on the next cycle
  logic [31:0] m0_q;
  logic [31:0] m0sq_q;
  logic [48:0] sub_full;
  logic [48:0] sq_ext;
  assign sub_full = 49'(cnt_q) * 49'(m0sq_q);
  assign sq_ext   = {1'b0, sq_sum_q};

  // square root, two bits per step over 48 bits
  logic [47:0] sv_q;
  logic [23:0] root_q;
  logic [25:0] srem_q;
  logic [4:0]  scnt_q;
  logic [25:0] srem_sh, trial;
  assign srem_sh = {srem_q[23:0], sv_q[47:46]};
  assign trial   = {root_q, 2'b01};
  assign sts_o.sqrt_done = (scnt_q == 5'd23);

  logic       err;
  logic [14:0] mean_sat;
  logic [15:0] std_sat;
  assign err      = (cnt_q == '0);
  assign mean_sat = (m0_q > 32'h7FFF) ? 15'h7FFF : m0_q[14:0];
  assign std_sat  = (root_q > 24'hFFFF) ? 16'hFFFF : root_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_sum_q   <= '0;
      sq_sum_q    <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      std_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_take_i) out_valid_o <= 1'b0;
      if (cmd_i.accum && in_item_i.mask_bit && (w != 0) && (32'(cnt_q) < COUNT_LIMIT)) begin
        abs_sum_q <= abs_sum_q + 32'(aw);
        sq_sum_q  <= sq_sum_q + 48'(aw_sq);
        cnt_q     <= cnt_q + 17'd1;
      end
      if (cmd_i.weight) begin
        out_valid_o <= 1'b1;
      end
      if (cmd_i.finish) begin
        mean_q      <= err ? '0 : mean_sat;
        std_q       <= err ? '0 : std_sat;
        abs_sum_q   <= '0;
        sq_sum_q    <= '0;
        cnt_q       <= '0;
        out_valid_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_fin) begin
      quo_q  <= 48'(abs_sum_q) + ((cmd_i.accum && in_item_i.mask_bit && (w != 0) &&
                (32'(cnt_q) < COUNT_LIMIT)) ? 48'(aw) : 48'd0);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.var_load) begin
      quo_q  <= (sq_ext > sub_full) ? 48'(sq_ext - sub_full) : '0;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[46:0], ge};
      rem_q  <= ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
      dcnt_q <= dcnt_q + 6'd1;
    end
    if (cmd_i.sub_mul) begin
      m0_q   <= err ? '0 : quo_q[31:0];
      m0sq_q <= err ? '0 : 32'(quo_q[15:0]) * 32'(quo_q[15:0]);
    end
    if (cmd_i.var_load) begin
      root_q <= '0;
      srem_q <= '0;
      scnt_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if (scnt_q == 5'd0) begin
        sv_q <= {quo_q[45:0], 2'b00};
        if ({24'd0, quo_q[47:46]} >= 26'd1) begin
          srem_q <= {24'd0, quo_q[47:46]} - 26'd1;
          root_q <= 24'd1;
        end else begin
          srem_q <= {24'd0, quo_q[47:46]};
          root_q <= 24'd0;
        end
      end else begin
        sv_q <= {sv_q[45:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_q <= srem_sh - trial;
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[22:0], 1'b0};
        end
      end
      scnt_q <= scnt_q + 5'd1;
    end
    if (cmd_i.weight) begin
      out_item_o.result_kind   <= KIND_WEIGHT;
      out_item_o.new_mask      <= nm;
      out_item_o.mask_changed  <= nm ^ in_item_i.mask_bit;
      out_item_o.masked_weight <= nm ? w : '0;
      out_item_o.mean_out      <= '0;
      out_item_o.stdev_out     <= '0;
      out_item_o.stats_error   <= 1'b0;
    end
    if (cmd_i.finish) begin
      out_item_o.result_kind   <= KIND_STATS;
      out_item_o.new_mask      <= 1'b0;
      out_item_o.mask_changed  <= 1'b0;
      out_item_o.masked_weight <= '0;
      out_item_o.mean_out      <= err ? '0 : mean_sat;
      out_item_o.stdev_out     <= err ? '0 : std_sat;
      out_item_o.stats_error   <= err;
    end
  end

endmodule

/* rtl/weight_prune_mask_updater.sv */
// Top level: weight prune mask updater with statistics pass.
// Usage:
//   Input channel in_valid/in_stall carries func, weight, mask bit and last flag.
//   Output channel out_valid/out_stall carries one result per update, apply
//   or closing statistics item; plain statistics items give no result.
//   crate is written through crate_we_i/crate_i; the user must do so
//   only while the block is idle, which the block does not enforce.
// Timing:
//   Statistics, update and apply items are taken while idle; a result is
//   registered and appears the cycle after the transfer.
//   A closing statistics item runs the mean divide, ST_SUB, ST_VLOAD, the
//   variance divide, 24 square-root steps and ST_FIN, taking no input.
// Stall:
//   While a result waits, statistics items are still taken; items that
//   produce a result wait until the output register is free.
// Reset:
//   Clears accumulators, latched mean and deviation, crate and output valid.
module weight_prune_mask_updater
  import wpm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  wpm_in_t     in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output wpm_out_t    out_data_o,
  input  logic        crate_we_i,
  input  logic [15:0] crate_i
);

  localparam int unsigned CountLimit = (MAX_ENTRIES < 131071) ? MAX_ENTRIES : 131071;

  logic [15:0] crate_q;
  wpm_cmd_t    cmd;
  wpm_sts_t    sts;
  logic        take;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crate_q <= '0;
    end else if (crate_we_i) begin
      crate_q <= crate_i;
    end
  end

  wpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_item_i  (in_data_i),
    .in_stall   (in_stall),
    .out_busy_i (out_valid && out_stall),
    .take_o     (take),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  wpm_datapath #(
    .COUNT_LIMIT (CountLimit)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_data_i),
    .crate_i     (crate_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_take_i  (out_take),
    .out_valid_o (out_valid),
    .out_item_o  (out_data_o)
  );

  a_cmd_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accum || cmd.weight) |-> take) else $error("command without transfer");
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.div_step, cmd.sub_mul, cmd.var_load, cmd.sqrt_step, cmd.finish}))
    else $error("overlapping phases");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid) else $error("statistics result lost");

endmodule
